/* design/upd_pkg.sv */
// shared types, character codes and helper functions for the url percent decoder
package upd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CMD_BYTES       = 3;

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       decoded_end;
    } t_out;

    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [1:0]                count;
        logic                      str_end;
    } t_cmd;

    function automatic logic is_hex(input logic [7:0] b);
        return (b inside {[8'd48:8'd57], [8'd97:8'd102], [8'd65:8'd70]});
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] b);
        logic [7:0] d;
        if (b inside {[8'd48:8'd57]}) begin
            d = b - 8'd48;
        end else if (b inside {[8'd97:8'd102]}) begin
            d = b - 8'd87;
        end else begin
            d = b - 8'd55;
        end
        return d[3:0];
    endfunction

    function automatic logic is_kept(input logic [7:0] v);
        return (v inside {[8'd48:8'd57], [8'd97:8'd122], [8'd65:8'd90],
                          8'h21, 8'h24, [8'h26:8'h2f], 8'h3a, 8'h3b, 8'h3d,
                          8'h3f, 8'h40, 8'h5f});
    endfunction

endpackage

/* design/url_percent_decoder.sv */
// top level of the url percent decoder
// Input channel: drive i_item (byte plus end-of-string flag) and raise push;
// a transfer happens on a clock edge with push high and full low.
// Output channel: while empty is low, o_result holds the oldest decoded byte;
// a transfer happens on a clock edge with pop high and empty low.
// Each input byte yields zero to three output bytes. run_last marks the final
// byte caused by one input, decoded_end the final byte of the string.
// A byte that gives output is written into the command queue and from there
// into the output register before it appears on o_result.
// Throughput: one input byte per cycle while each yields at most one
// output byte and the receiver keeps pop high; the output side moves one
// byte per cycle while pop is high, so the command queue (QUEUE_DEPTH
// entries) absorbs bytes that expand to more outputs before full rises.
// When the receiver holds pop low, the output register keeps its byte, the
// queue fills, and then full stops the sender; nothing is dropped.
// Reset (synchronous, active low) clears the escape state, empties the queue
// and the output register; no clearing pass is needed.
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  upd_pkg::t_in   i_item,
    output logic           empty,
    input  logic           pop,
    output upd_pkg::t_out  o_result
);
    import upd_pkg::*;

    logic w_accept;
    t_cmd w_cmd;
    logic w_cmd_valid;
    t_cmd w_head;
    logic w_q_empty;
    logic w_q_full;
    logic w_head_pop;

    assign w_accept = push && !w_q_full;
    assign full     = w_q_full;

    upd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cmd_valid),
        .i_wdata (w_cmd),
        .i_rd    (w_head_pop),
        .o_rdata (w_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    upd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (!w_q_empty),
        .o_head_pop   (w_head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("outputs not idle after reset");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.decoded_end |-> o_result.run_last)
        else $error("string end without run end");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_q_empty)
        else $error("queue full and empty at once");

    a_head_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_head_pop |-> !w_q_empty && w_head.count != 2'd0)
        else $error("command consumed from empty queue");

endmodule

/* design/upd_front.sv */
// front end: tracks escape phase and turns each input byte into a short output command
module upd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  upd_pkg::t_in  i_item,
    output upd_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid
);
    import upd_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    t_phase     w_mid_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;

    logic [7:0] w_b;
    logic       w_hex;
    logic       w_f_emit;
    logic       w_f_open;
    logic [7:0] w_f_byte;
    logic [7:0] w_val;
    t_cmd       w_cmd;

    assign w_b      = i_item.in_byte;
    assign w_hex    = is_hex(w_b);
    assign w_f_emit = (w_b != CH_PCT);
    assign w_f_open = (w_b == CH_PCT);
    assign w_f_byte = (w_b == CH_PLUS) ? CH_SPACE : w_b;
    assign w_val    = {nibble_of(r_held), nibble_of(w_b)};

    // next state
    always_comb begin
        w_mid_phase = PH_IDLE;
        n_held      = r_held;
        case (r_phase)
            PH_PCT: begin
                if (w_hex) begin
                    w_mid_phase = PH_DIGIT;
                    n_held      = w_b;
                end else begin
                    w_mid_phase = w_f_open ? PH_PCT : PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (w_hex) begin
                    w_mid_phase = PH_IDLE;
                end else begin
                    w_mid_phase = w_f_open ? PH_PCT : PH_IDLE;
                end
            end
            default: begin
                w_mid_phase = w_f_open ? PH_PCT : PH_IDLE;
            end
        endcase
        n_phase = i_item.string_end ? PH_IDLE : w_mid_phase;
    end

    // output command
    always_comb begin
        w_cmd         = '0;
        w_cmd.str_end = i_item.string_end;
        case (r_phase)
            PH_PCT: begin
                if (!w_hex) begin
                    w_cmd.bytes[0] = CH_PCT;
                    w_cmd.bytes[1] = w_f_byte;
                    w_cmd.count    = w_f_emit ? 2'd2 : 2'd1;
                end
            end
            PH_DIGIT: begin
                if (w_hex) begin
                    if (is_kept(w_val)) begin
                        w_cmd.bytes[0] = CH_PCT;
                        w_cmd.bytes[1] = r_held;
                        w_cmd.bytes[2] = w_b;
                        w_cmd.count    = 2'd3;
                    end else begin
                        w_cmd.bytes[0] = w_val;
                        w_cmd.count    = 2'd1;
                    end
                end else begin
                    w_cmd.bytes[0] = CH_PCT;
                    w_cmd.bytes[1] = r_held;
                    w_cmd.bytes[2] = w_f_byte;
                    w_cmd.count    = w_f_emit ? 2'd3 : 2'd2;
                end
            end
            default: begin
                w_cmd.bytes[0] = w_f_byte;
                w_cmd.count    = w_f_emit ? 2'd1 : 2'd0;
            end
        endcase
        // flush a pending escape at the end of the string
        if (i_item.string_end) begin
            if (w_mid_phase == PH_PCT) begin
                case (w_cmd.count)
                    2'd0:    w_cmd.bytes[0] = CH_PCT;
                    2'd1:    w_cmd.bytes[1] = CH_PCT;
                    default: w_cmd.bytes[2] = CH_PCT;
                endcase
                w_cmd.count = w_cmd.count + 2'd1;
            end else if (w_mid_phase == PH_DIGIT) begin
                w_cmd.bytes[0] = CH_PCT;
                w_cmd.bytes[1] = n_held;
                w_cmd.count    = 2'd2;
            end
        end
    end

    assign o_cmd       = w_cmd;
    assign o_cmd_valid = i_accept && (w_cmd.count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

/* design/upd_queue.sv */
// small command queue between the front end and the output sequencer
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  upd_pkg::t_cmd i_wdata,
    input  logic          i_rd,
    output upd_pkg::t_cmd o_rdata,
    output logic          o_full,
    output logic          o_empty
);
    import upd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_wr;
    logic             w_do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_wr && !w_do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_rd && !w_do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/upd_back.sv */
// back end: walks the bytes of each command into the output register
module upd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upd_pkg::t_cmd i_head,
    input  logic          i_head_valid,
    output logic          o_head_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output upd_pkg::t_out o_result
);
    import upd_pkg::*;

    logic       r_valid;
    t_out       r_out;
    logic [1:0] r_idx;
    logic       w_load;
    logic       w_take;
    logic       w_last_byte;
    logic [7:0] w_byte;

    assign w_load      = !r_valid || i_pop;
    assign w_take      = w_load && i_head_valid;
    assign w_last_byte = (r_idx == (i_head.count - 2'd1));
    assign o_head_pop  = w_take && w_last_byte;
    assign o_empty     = !r_valid;
    assign o_result    = r_out;

    always_comb begin
        case (r_idx)
            2'd0:    w_byte = i_head.bytes[0];
            2'd1:    w_byte = i_head.bytes[1];
            default: w_byte = i_head.bytes[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= w_take;
            if (w_take) begin
                r_idx <= w_last_byte ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out.out_byte    <= w_byte;
            r_out.run_last    <= w_last_byte;
            r_out.decoded_end <= w_last_byte && i_head.str_end;
        end
    end

endmodule

/* dv/tb.sv */
// self-checking testbench for the url percent decoder
`timescale 1ns / 1ps

module tb;
    import upd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_ITEMS  = 35;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] in_byte;
        logic       string_end;
        bit         typed;
        logic [7:0] exp_byte;
    } t_dir_row;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  push    = 1'b0;
    logic  pop     = 1'b0;
    t_in   i_item  = '0;
    logic  full;
    logic  empty;
    t_out  o_result;

    t_phase     esc_state = PH_IDLE;
    logic [7:0] held_hex  = 8'h00;
    t_out       step_out[$];
    t_out       decoded_q[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_rx       = 1'b0;
    int  cycles        = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  failures      = 0;

    // hex digits, broken escapes, kept values, flushes at end of string
    t_dir_row dir_tab[27] = '{
        '{8'h61, 1'b0, 1'b1, 8'h61},
        '{CH_PLUS, 1'b0, 1'b1, CH_SPACE},
        '{8'h00, 1'b0, 1'b1, 8'h00},
        '{8'hff, 1'b0, 1'b1, 8'hff},
        '{CH_PCT, 1'b0, 1'b0, 8'h00},
        '{8'h32, 1'b0, 1'b0, 8'h00},
        '{8'h30, 1'b0, 1'b0, 8'h00},
        '{CH_PCT, 1'b0, 1'b0, 8'h00},
        '{8'h34, 1'b0, 1'b0, 8'h00},
        '{8'h31, 1'b0, 1'b0, 8'h00},
        '{CH_PCT, 1'b0, 1'b0, 8'h00},
        '{8'h67, 1'b0, 1'b0, 8'h00},
        '{CH_PCT, 1'b0, 1'b0, 8'h00},
        '{8'h33, 1'b0, 1'b0, 8'h00},
        '{8'h7a, 1'b0, 1'b0, 8'h00},
        '{CH_PCT, 1'b0, 1'b0, 8'h00},
        '{CH_PCT, 1'b0, 1'b0, 8'h00},
        '{CH_PLUS, 1'b0, 1'b0, 8'h00},
        '{CH_PCT, 1'b0, 1'b0, 8'h00},
        '{8'h46, 1'b0, 1'b0, 8'h00},
        '{8'h46, 1'b0, 1'b0, 8'h00},
        '{CH_PCT, 1'b0, 1'b0, 8'h00},
        '{8'h66, 1'b0, 1'b0, 8'h00},
        '{8'h80, 1'b1, 1'b0, 8'h00},
        '{CH_PCT, 1'b1, 1'b1, CH_PCT},
        '{CH_PCT, 1'b0, 1'b0, 8'h00},
        '{8'h61, 1'b1, 1'b0, 8'h00}
    };

    url_percent_decoder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        if (c <= 8'h39) begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    function automatic bit keeps_literal(input logic [7:0] v);
        if ((v >= 8'h30 && v <= 8'h39) || (v >= 8'h41 && v <= 8'h5a) ||
            (v >= 8'h61 && v <= 8'h7a)) begin
            return 1'b1;
        end
        case (v)
            8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c,
            8'h2d, 8'h2e, 8'h2f, 8'h3a, 8'h3b, 8'h3d, 8'h3f, 8'h40, 8'h5f: begin
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + nib;
        end
        return ($urandom_range(1) ? 8'h37 : 8'h57) + nib;
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        t_out r;
        r.out_byte    = b;
        r.run_last    = 1'b0;
        r.decoded_end = 1'b0;
        step_out.push_back(r);
    endtask

    task automatic plain_byte(input logic [7:0] b);
        if (b == CH_PLUS) begin
            emit_byte(CH_SPACE);
        end else if (b == CH_PCT) begin
            esc_state = PH_PCT;
        end else begin
            emit_byte(b);
        end
    endtask

    task automatic decode_byte(input t_in it);
        logic [7:0] b;
        logic [7:0] v;
        t_phase     ph;
        step_out.delete();
        b = it.in_byte;
        ph = esc_state;
        esc_state = PH_IDLE;
        case (ph)
            PH_PCT: begin
                if (is_hex_char(b)) begin
                    held_hex = b;
                    esc_state = PH_DIGIT;
                end else begin
                    emit_byte(CH_PCT);
                    plain_byte(b);
                end
            end
            PH_DIGIT: begin
                if (is_hex_char(b)) begin
                    v = {hex_nib(held_hex), hex_nib(b)};
                    if (keeps_literal(v)) begin
                        emit_byte(CH_PCT);
                        emit_byte(held_hex);
                        emit_byte(b);
                    end else begin
                        emit_byte(v);
                    end
                end else begin
                    emit_byte(CH_PCT);
                    emit_byte(held_hex);
                    plain_byte(b);
                end
            end
            default: begin
                plain_byte(b);
            end
        endcase
        if (it.string_end) begin
            if (esc_state == PH_PCT) begin
                emit_byte(CH_PCT);
            end else if (esc_state == PH_DIGIT) begin
                emit_byte(CH_PCT);
                emit_byte(held_hex);
            end
            esc_state = PH_IDLE;
        end
        if (step_out.size() > 0) begin
            step_out[step_out.size()-1].run_last    = 1'b1;
            step_out[step_out.size()-1].decoded_end = it.string_end;
        end
    endtask

    task automatic offer(input t_in it, input bit typed, input logic [7:0] exp_byte);
        t_out want;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        items_sent++;
        decode_byte(it);
        if (typed) begin
            want.out_byte    = exp_byte;
            want.run_last    = 1'b1;
            want.decoded_end = it.string_end;
            decoded_q.push_back(want);
        end else begin
            foreach (step_out[k]) decoded_q.push_back(step_out[k]);
        end
    endtask

    task automatic send_random_string();
        logic [7:0] str_q[$];
        logic [7:0] v;
        int         r;
        t_in        it;
        repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(99);
            v = 8'($urandom_range(255));
            if (r < 35) begin
                str_q.push_back(CH_PCT);
                str_q.push_back(hex_char(v[7:4]));
                str_q.push_back(hex_char(v[3:0]));
            end else if (r < 45) begin
                str_q.push_back(CH_PLUS);
            end else if (r < 55) begin
                str_q.push_back(CH_PCT);
            end else if (r < 65) begin
                str_q.push_back(CH_PCT);
                str_q.push_back(hex_char(v[3:0]));
            end else if (r < 80) begin
                str_q.push_back(v);
            end else begin
                str_q.push_back(8'($urandom_range(32, 126)));
            end
        end
        foreach (str_q[k]) begin
            it.in_byte    = str_q[k];
            it.string_end = (k == str_q.size() - 1);
            offer(it, 1'b0, 8'h00);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // output side: check each transfer, then pick pop for the next edge
    always @(posedge i_clk) begin : rx_side
        t_out want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    failures++;
                    if (mismatches < MAX_REPORTS) begin
                        $display("tb: unexpected result byte=%02h run_last=%0b end=%0b",
                                 o_result.out_byte, o_result.run_last,
                                 o_result.decoded_end);
                    end
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_result.out_byte !== want.out_byte ||
                        o_result.run_last !== want.run_last ||
                        o_result.decoded_end !== want.decoded_end) begin
                        failures++;
                        if (mismatches < MAX_REPORTS) begin
                            $display("tb: mismatch byte %02h/%02h run_last %0b/%0b end %0b/%0b",
                                     want.out_byte, o_result.out_byte,
                                     want.run_last, o_result.run_last,
                                     want.decoded_end, o_result.decoded_end);
                        end
                        mismatches++;
                    end
                end
            end
            pop <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin : main
        int phase_start;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            offer('{dir_tab[k].in_byte, dir_tab[k].string_end}, dir_tab[k].typed,
                  dir_tab[k].exp_byte);
        end
        drain();

        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        phase_start = items_sent;
        while (items_sent - phase_start < 20) send_random_string();
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 63; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 63; end
                default: begin send_idle_pct = 24; recv_idle_pct = 24; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_random_string();
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            failures++;
            $display("tb: %0d expected results never arrived", decoded_q.size());
        end
        $display("tb: %0d bytes in, %0d bytes out checked; idle mixes, long output stall",
                 items_sent, results_seen);
        $display("tb: %0d mismatches", mismatches);
        if (failures == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
